>>> src/bma_pkg.sv
package bma_pkg;

    // fixed field widths of the command and response channels
    localparam int LEN_W    = 14;
    localparam int ADDR_W   = 13;
    localparam int USED_W   = 9;
    localparam int STATUS_W = 2;

    localparam int DEF_NUM_BLOCKS  = 256;
    localparam int DEF_BLOCK_BYTES = 32;

    localparam logic CMD_ALLOC = 1'b0;
    localparam logic CMD_FREE  = 1'b1;

    localparam logic [STATUS_W-1:0] STAT_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] STAT_ZERO_LEN = 2'd1;
    localparam logic [STATUS_W-1:0] STAT_NO_RUN   = 2'd2;
    localparam logic [STATUS_W-1:0] STAT_BAD_ADDR = 2'd3;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_DIV,
        ST_A_SCAN,
        ST_A_MARK,
        ST_F_SIZE,
        ST_F_CLR,
        ST_RESP
    } bma_state_t;

endpackage

>>> src/block_map_allocator.sv
// Block map allocator: hands out runs of fixed-size blocks from a pool and
// frees them again, tracking ownership in a map memory of one entry per block.
// Command channel (cmd_valid/cmd_ready): command, length_bytes, free_address.
// Response channel (rsp_valid/rsp_ready): status, alloc_address, used_blocks.
// One response per command. Commands are processed one at a time; cmd_ready
// is high whenever the sequencer is idle, even while a response still waits.
// Sequence of steps, set by the single-port walk over the map memory:
//   allocate: accept, block count, scan of entries from the top (up to
//             NUM_BLOCKS entries), marking of the run found, response;
//   free:     accept, block index, reading and clearing of the run's
//             entries, response;
//   request too large: accept, block count, response;
//   zero length or bad address: accept, response.
// After reset a clearing pass writes every map entry to zero, during which
// cmd_ready stays low.
// A response stalled by rsp_ready low holds in the output register; the next
// command is still accepted and its result waits in the sequencer until the
// output register frees up.
module block_map_allocator
    import bma_pkg::*;
#(
    parameter int NUM_BLOCKS  = DEF_NUM_BLOCKS,
    parameter int BLOCK_BYTES = DEF_BLOCK_BYTES
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cmd_valid,
    output logic                cmd_ready,
    input  logic                command,
    input  logic [LEN_W-1:0]    length_bytes,
    input  logic [ADDR_W-1:0]   free_address,
    output logic                rsp_valid,
    input  logic                rsp_ready,
    output logic [STATUS_W-1:0] status,
    output logic [ADDR_W-1:0]   alloc_address,
    output logic [USED_W-1:0]   used_blocks
);

    localparam int AW         = (NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1;
    localparam int CW         = $clog2(NUM_BLOCKS + 1);
    localparam int POOL_BYTES = NUM_BLOCKS * BLOCK_BYTES;

    // dividend is at most length + block size - 1, which fits 15 bits
    localparam int DIV_IN_W = LEN_W + 1;
    localparam int DIV_SH   = DIV_IN_W + $clog2(BLOCK_BYTES);
    localparam int RECIP_W  = DIV_IN_W + 2;
    localparam int PROD_W   = DIV_IN_W + RECIP_W;
    localparam logic [RECIP_W-1:0] RECIP =
        RECIP_W'(((longint'(1) << DIV_SH) + longint'(BLOCK_BYTES) - 1)
                 / longint'(BLOCK_BYTES));

    localparam logic [AW-1:0] TOP_IDX = AW'(NUM_BLOCKS - 1);

    // map memory, registered read
    logic [CW-1:0] map_mem [NUM_BLOCKS];
    logic          mem_we;
    logic [AW-1:0] mem_waddr;
    logic [CW-1:0] mem_wdata;
    logic          mem_re;
    logic [AW-1:0] mem_raddr;
    logic [CW-1:0] rd_data_reg;

    bma_state_t state_reg, state_next;
    logic [AW-1:0]       ptr_reg, ptr_next;
    logic [CW-1:0]       run_reg, run_next;
    logic [CW-1:0]       cnt_reg, cnt_next;
    logic [CW-1:0]       need_reg, need_next;
    logic [AW-1:0]       base_reg, base_next;
    logic [CW-1:0]       used_reg, used_next;
    logic                cmd_reg, cmd_next;
    logic [DIV_IN_W-1:0] div_in_reg, div_in_next;
    logic [STATUS_W-1:0] res_status_reg, res_status_next;
    logic [ADDR_W-1:0]   res_addr_reg, res_addr_next;
    logic                rsp_valid_reg, rsp_valid_next;
    logic [STATUS_W-1:0] status_reg, status_next;
    logic [ADDR_W-1:0]   alloc_address_reg, alloc_address_next;
    logic [USED_W-1:0]   used_blocks_reg, used_blocks_next;

    // block count by reciprocal multiplication, exact over the dividend range
    logic [PROD_W-1:0] div_prod;
    logic [LEN_W-1:0]  div_quo;
    logic [CW-1:0]     run_inc;
    logic [CW-1:0]     cnt_inc;

    assign div_prod = PROD_W'(div_in_reg) * PROD_W'(RECIP);
    assign div_quo  = LEN_W'(div_prod >> DIV_SH);
    assign run_inc  = (rd_data_reg == '0) ? (run_reg + CW'(1)) : '0;
    assign cnt_inc  = cnt_reg + CW'(1);

    assign cmd_ready     = (state_reg == ST_IDLE);
    assign rsp_valid     = rsp_valid_reg;
    assign status        = status_reg;
    assign alloc_address = alloc_address_reg;
    assign used_blocks   = used_blocks_reg;

    always_comb
    begin
        state_next         = state_reg;
        ptr_next           = ptr_reg;
        run_next           = run_reg;
        cnt_next           = cnt_reg;
        need_next          = need_reg;
        base_next          = base_reg;
        used_next          = used_reg;
        cmd_next           = cmd_reg;
        div_in_next        = div_in_reg;
        res_status_next    = res_status_reg;
        res_addr_next      = res_addr_reg;
        rsp_valid_next     = rsp_valid_reg;
        status_next        = status_reg;
        alloc_address_next = alloc_address_reg;
        used_blocks_next   = used_blocks_reg;
        mem_we             = 1'b0;
        mem_waddr          = ptr_reg;
        mem_wdata          = '0;
        mem_re             = 1'b0;
        mem_raddr          = ptr_reg;

        if (rsp_valid_reg && rsp_ready)
        begin
            rsp_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_CLEAR:
            begin
                mem_we = 1'b1;
                if (ptr_reg == TOP_IDX)
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    ptr_next = ptr_reg + AW'(1);
                end
            end

            ST_IDLE:
            begin
                if (cmd_valid)
                begin
                    cmd_next      = command;
                    res_addr_next = '0;
                    priority if (command == CMD_ALLOC && length_bytes == '0)
                    begin
                        res_status_next = STAT_ZERO_LEN;
                        state_next      = ST_RESP;
                    end
                    else if (command == CMD_FREE && 32'(free_address) >= POOL_BYTES)
                    begin
                        res_status_next = STAT_BAD_ADDR;
                        state_next      = ST_RESP;
                    end
                    else
                    begin
                        // rounding up for allocate folds into the dividend
                        div_in_next = (command == CMD_ALLOC)
                                      ? DIV_IN_W'(length_bytes)
                                        + DIV_IN_W'(BLOCK_BYTES - 1)
                                      : DIV_IN_W'(free_address);
                        state_next  = ST_DIV;
                    end
                end
            end

            ST_DIV:
            begin
                if (cmd_reg == CMD_ALLOC)
                begin
                    if (32'(div_quo) > NUM_BLOCKS)
                    begin
                        res_status_next = STAT_NO_RUN;
                        state_next      = ST_RESP;
                    end
                    else
                    begin
                        need_next  = CW'(div_quo);
                        run_next   = '0;
                        ptr_next   = TOP_IDX;
                        mem_re     = 1'b1;
                        mem_raddr  = TOP_IDX;
                        state_next = ST_A_SCAN;
                    end
                end
                else
                begin
                    // address already range-checked, quotient fits the index
                    ptr_next   = AW'(div_quo);
                    mem_re     = 1'b1;
                    mem_raddr  = AW'(div_quo);
                    state_next = ST_F_SIZE;
                end
            end

            // rd_data_reg holds the entry at ptr_reg; next read issued ahead
            ST_A_SCAN:
            begin
                run_next = run_inc;
                if (run_inc == need_reg)
                begin
                    base_next  = ptr_reg;
                    cnt_next   = '0;
                    state_next = ST_A_MARK;
                end
                else if (ptr_reg == '0)
                begin
                    res_status_next = STAT_NO_RUN;
                    state_next      = ST_RESP;
                end
                else
                begin
                    ptr_next  = ptr_reg - AW'(1);
                    mem_re    = 1'b1;
                    mem_raddr = ptr_reg - AW'(1);
                end
            end

            ST_A_MARK:
            begin
                mem_we    = 1'b1;
                mem_wdata = need_reg;
                cnt_next  = cnt_inc;
                ptr_next  = ptr_reg + AW'(1);
                if (cnt_inc == need_reg)
                begin
                    used_next       = used_reg + need_reg;
                    res_status_next = STAT_OK;
                    res_addr_next   = ADDR_W'(32'(base_reg) * BLOCK_BYTES);
                    state_next      = ST_RESP;
                end
            end

            // first entry gives the run length and, if nonzero, is itself in use
            ST_F_SIZE:
            begin
                res_status_next = STAT_OK;
                if (rd_data_reg == '0)
                begin
                    state_next = ST_RESP;
                end
                else
                begin
                    need_next = rd_data_reg;
                    mem_we    = 1'b1;
                    used_next = used_reg - CW'(1);
                    cnt_next  = CW'(1);
                    if (rd_data_reg == CW'(1) || ptr_reg == TOP_IDX)
                    begin
                        state_next = ST_RESP;
                    end
                    else
                    begin
                        ptr_next   = ptr_reg + AW'(1);
                        mem_re     = 1'b1;
                        mem_raddr  = ptr_reg + AW'(1);
                        state_next = ST_F_CLR;
                    end
                end
            end

            // reads run strictly ahead of writes, so no entry is read stale
            ST_F_CLR:
            begin
                if (rd_data_reg != '0)
                begin
                    mem_we    = 1'b1;
                    used_next = used_reg - CW'(1);
                end
                cnt_next = cnt_inc;
                if (cnt_inc == need_reg || ptr_reg == TOP_IDX)
                begin
                    state_next = ST_RESP;
                end
                else
                begin
                    ptr_next  = ptr_reg + AW'(1);
                    mem_re    = 1'b1;
                    mem_raddr = ptr_reg + AW'(1);
                end
            end

            ST_RESP:
            begin
                if (!rsp_valid_reg || rsp_ready)
                begin
                    rsp_valid_next     = 1'b1;
                    status_next        = res_status_reg;
                    alloc_address_next = res_addr_reg;
                    used_blocks_next   = USED_W'(used_reg);
                    state_next         = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            ptr_reg       <= '0;
            used_reg      <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            ptr_reg       <= ptr_next;
            used_reg      <= used_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        run_reg           <= run_next;
        cnt_reg           <= cnt_next;
        need_reg          <= need_next;
        base_reg          <= base_next;
        cmd_reg           <= cmd_next;
        div_in_reg        <= div_in_next;
        res_status_reg    <= res_status_next;
        res_addr_reg      <= res_addr_next;
        status_reg        <= status_next;
        alloc_address_reg <= alloc_address_next;
        used_blocks_reg   <= used_blocks_next;
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            map_mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re)
        begin
            rd_data_reg <= map_mem[mem_raddr];
        end
    end

    a_used_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        used_reg <= CW'(NUM_BLOCKS))
        else $error("used block count beyond pool size");

    a_scan_no_write: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_A_SCAN || state_reg == ST_DIV) |-> !mem_we)
        else $error("map written during scan or divide");

    a_resp_load: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_RESP && (!rsp_valid_reg || rsp_ready))
            |=> (rsp_valid_reg && state_reg == ST_IDLE))
        else $error("pending result not moved to output register");

    a_addr_only_ok: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid_reg && status_reg != STAT_OK) |-> (alloc_address_reg == '0))
        else $error("nonzero address on a failed transaction");

endmodule

>>> bench/tb_block_map_allocator.sv
module tb_block_map_allocator;
    import bma_pkg::*;

    localparam int NB          = DEF_NUM_BLOCKS;
    localparam int BB          = DEF_BLOCK_BYTES;
    localparam int POOL_BYTES  = NB * BB;
    localparam int CYCLE_LIMIT = 1_000_000;
    localparam int SETTLE_CYC  = 600;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [ADDR_W-1:0]   addr;
        logic [USED_W-1:0]   used;
    } pool_result_t;

    logic                clk = 1'b0;
    logic                rst_n;
    logic                cmd_valid;
    logic                cmd_ready;
    logic                command;
    logic [LEN_W-1:0]    length_bytes;
    logic [ADDR_W-1:0]   free_address;
    logic                rsp_valid;
    logic                rsp_ready = 1'b0;
    logic [STATUS_W-1:0] status;
    logic [ADDR_W-1:0]   alloc_address;
    logic [USED_W-1:0]   used_blocks;

    // shadow of the block map and its used count
    logic [USED_W-1:0] map_entry [NB];
    int                pool_used;
    pool_result_t      pending_results[$];
    int                live_runs[$];
    int                error_count = 0;
    int                cycle_count = 0;
    bit                idle_on = 1'b1;

    block_map_allocator #(
        .NUM_BLOCKS  (NB),
        .BLOCK_BYTES (BB)
    ) u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd_valid     (cmd_valid),
        .cmd_ready     (cmd_ready),
        .command       (command),
        .length_bytes  (length_bytes),
        .free_address  (free_address),
        .rsp_valid     (rsp_valid),
        .rsp_ready     (rsp_ready),
        .status        (status),
        .alloc_address (alloc_address),
        .used_blocks   (used_blocks)
    );

    always #4 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles", cycle_count);
            $display("Test completed with failures");
            $finish;
        end
    end

    always @(negedge clk)
    begin
        rsp_ready <= !idle_on || ($urandom_range(99) >= 33);
    end

    task automatic report_mismatch(input string msg);
        $display("ERROR: %s", msg);
        error_count++;
    endtask

    function automatic pool_result_t predict_pool_cmd(input logic cmd,
                                                      input logic [LEN_W-1:0] len,
                                                      input logic [ADDR_W-1:0] addr);
        pool_result_t r;
        int           need;
        int           run;
        int           start;
        int           size;
        r = '0;
        if (cmd == CMD_ALLOC)
        begin
            need = (int'(len) + BB - 1) / BB;
            r.status = STAT_NO_RUN;
            if (len == 0)
                r.status = STAT_ZERO_LEN;
            else if (need <= NB)
            begin
                run = 0;
                // top-down scan, the first run long enough wins
                for (int b = NB - 1; b >= 0; b--)
                begin
                    run = (map_entry[b] == 0) ? run + 1 : 0;
                    if (run == need)
                    begin
                        for (int i = 0; i < need; i++)
                            map_entry[b + i] = USED_W'(need);
                        pool_used += need;
                        r.status = STAT_OK;
                        r.addr = ADDR_W'(b * BB);
                        break;
                    end
                end
            end
        end
        else if (int'(addr) >= POOL_BYTES)
            r.status = STAT_BAD_ADDR;
        else
        begin
            start = int'(addr) / BB;
            size = map_entry[start];
            // clearing follows the stored length, clipped at the last block
            for (int i = 0; i < size && start + i < NB; i++)
            begin
                if (map_entry[start + i] != 0)
                begin
                    map_entry[start + i] = '0;
                    pool_used--;
                end
            end
            r.status = STAT_OK;
        end
        r.used = USED_W'(pool_used);
        return r;
    endfunction

    // call just after a falling edge; returns just after a falling edge
    task automatic send_cmd(input logic cmd, input int len, input int addr);
        pool_result_t r;
        while (idle_on && $urandom_range(99) < 33)
        begin
            cmd_valid <= 1'b0;
            @(negedge clk);
        end
        cmd_valid    <= 1'b1;
        command      <= cmd;
        length_bytes <= LEN_W'(len);
        free_address <= ADDR_W'(addr);
        do
            @(posedge clk);
        while (!cmd_ready);
        r = predict_pool_cmd(cmd, LEN_W'(len), ADDR_W'(addr));
        pending_results.push_back(r);
        if (cmd == CMD_ALLOC && r.status == STAT_OK)
            live_runs.push_back(int'(r.addr));
        @(negedge clk);
    endtask

    task automatic wait_all_results;
        cmd_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(negedge clk);
        @(negedge clk);
    endtask

    always @(posedge clk)
    begin
        pool_result_t e;
        if (rst_n && rsp_valid && rsp_ready)
        begin
            if (pending_results.size() == 0)
                report_mismatch("result with no command outstanding");
            else
            begin
                e = pending_results.pop_front();
                if (status !== e.status)
                    report_mismatch($sformatf("status got %0d exp %0d", status, e.status));
                if (alloc_address !== e.addr)
                    report_mismatch($sformatf("alloc_address got %0d exp %0d",
                                              alloc_address, e.addr));
                if (used_blocks !== e.used)
                    report_mismatch($sformatf("used_blocks got %0d exp %0d",
                                              used_blocks, e.used));
            end
        end
    end

    task automatic test_alloc_corners;
        send_cmd(CMD_ALLOC, 0, 0);
        send_cmd(CMD_ALLOC, 1, 0);
        send_cmd(CMD_ALLOC, BB, 0);
        send_cmd(CMD_ALLOC, BB + 1, 0);
        send_cmd(CMD_ALLOC, POOL_BYTES + 1, 0);
        send_cmd(CMD_ALLOC, 16383, 8191);
        send_cmd(CMD_ALLOC, POOL_BYTES, 0);
    endtask

    task automatic test_free_corners;
        send_cmd(CMD_FREE, 0, (NB - 1) * BB + 5);    // misaligned
        send_cmd(CMD_FREE, 16383, (NB - 3) * BB);    // second block of a two-block run
        send_cmd(CMD_FREE, 0, 0);                    // already free
        send_cmd(CMD_FREE, 0, 8191);
        send_cmd(CMD_ALLOC, 3 * BB, 0);
        send_cmd(CMD_FREE, 0, (NB - 1) * BB);        // runs off the end of the map
    endtask

    task automatic test_pool_full;
        for (int b = 0; b < NB; b++)
            if (map_entry[b] != 0)
                send_cmd(CMD_FREE, 0, b * BB);
        send_cmd(CMD_ALLOC, POOL_BYTES, 0);
        send_cmd(CMD_ALLOC, 1, 0);
        send_cmd(CMD_FREE, 0, 0);
        live_runs.delete();
    endtask

    task automatic test_random_churn(input int n_items);
        int idx;
        int addr;
        int pct;
        for (int n = 0; n < n_items; n++)
        begin
            pct = (pool_used > NB * 3 / 4) ? 70 : 40;
            if ($urandom_range(99) < 10)
                send_cmd($urandom_range(1), $urandom_range(16383), $urandom_range(8191));
            else if (live_runs.size() != 0 && $urandom_range(99) < pct)
            begin
                idx = $urandom_range(live_runs.size() - 1);
                addr = live_runs[idx];
                live_runs.delete(idx);
                if ($urandom_range(1))
                    addr += $urandom_range(BB - 1);
                send_cmd(CMD_FREE, $urandom_range(16383), addr);
            end
            else if ($urandom_range(99) < 5)
                send_cmd(CMD_ALLOC, $urandom_range(1, POOL_BYTES), $urandom_range(8191));
            else
                send_cmd(CMD_ALLOC, $urandom_range(1, 8 * BB), $urandom_range(8191));
        end
    endtask

    initial
    begin
        for (int b = 0; b < NB; b++)
            map_entry[b] = '0;
        pool_used    = 0;
        rst_n        = 1'b0;
        cmd_valid    = 1'b0;
        command      = CMD_ALLOC;
        length_bytes = '0;
        free_address = '0;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_alloc_corners();
        test_free_corners();
        test_pool_full();
        test_random_churn(300);
        wait_all_results();
        idle_on = 1'b0;
        test_random_churn(180);
        idle_on = 1'b1;
        test_random_churn(20);

        cmd_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYC) @(negedge clk);
        if (error_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
